// File: rtl/core/pma_pkg.sv
// pma_pkg: shared constants, register codes and controller/datapath
// command and status types for the 1-D max/average pooling unit.
// No dependencies.
package pma_pkg;

    localparam int MAX_KERNEL   = 8;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_WIDTH    = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_RESULTS  = 8;

    localparam int KER_BITS   = $clog2(MAX_KERNEL);
    localparam int CH_BITS    = $clog2(MAX_CHANNELS);
    localparam int ADDR_BITS  = KER_BITS + CH_BITS;
    localparam int STORE_DEPTH = MAX_KERNEL * MAX_CHANNELS;
    localparam int COL_BITS   = 10;
    localparam int OCOL_BITS  = 11;
    localparam int SUM_BITS   = SAMPLE_BITS + KER_BITS;
    localparam int PADDR_BITS = 5;

    // register map (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_METHOD       = 3'd0,
        REG_KERNEL_SIZE  = 3'd1,
        REG_STRIDE       = 3'd2,
        REG_CHANNELS     = 3'd3,
        REG_INPUT_WIDTH  = 3'd4,
        REG_OUTPUT_WIDTH = 3'd5,
        REG_PAD_LEFT     = 3'd6,
        REG_RECIP_KERNEL = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        method;
        logic [3:0]  kernel_size;
        logic [3:0]  stride;
        logic [6:0]  channels;
        logic [10:0] input_width;
        logic [10:0] output_width;
        logic [2:0]  pad_left;
        logic [15:0] recip_kernel;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic cmp;
        logic rd;
        logic avg;
        logic fin;
        logic push;
        logic adv_init;
        logic adv_step;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic qual;
        logic rd_done;
        logic pend_valid;
        logic out_free;
        logic wrap;
        logic adv_more;
        logic need_avg;
    } t_sts;

endpackage

// File: rtl/core/pma_if.sv
// pma_if: valid/ready word channels for sample input and pooled output.
// Depends on pma_pkg.
interface pma_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pma_pkg::SAMPLE_BITS-1:0]   sample;
    logic                                     start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface pma_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pma_pkg::SAMPLE_BITS-1:0]   pooled_value;
    logic [9:0]                               out_column;
    logic [5:0]                               out_channel;
    logic                                     run_last;

    modport source (output valid, output pooled_value, output out_column,
                    output out_channel, output run_last, input ready);
    modport sink   (input valid, input pooled_value, input out_column,
                    input out_channel, input run_last, output ready);
endinterface

// File: rtl/core/pma_ram.sv
// pma_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module pma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/pma_ctrl.sv
// pma_ctrl: sequencer for the pooling unit; walks windows, taps and the
// column advance. Depends on pma_pkg.
module pma_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pma_pkg::t_sts   i_sts,
    output pma_pkg::t_cmd   o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MUL  = 11'b000_0000_0010,
        S_CMP  = 11'b000_0000_0100,
        S_DEC  = 11'b000_0000_1000,
        S_PUSH = 11'b000_0001_0000,
        S_RD   = 11'b000_0010_0000,
        S_AVG  = 11'b000_0100_0000,
        S_FIN  = 11'b000_1000_0000,
        S_POST = 11'b001_0000_0000,
        S_ADVI = 11'b010_0000_0000,
        S_ADV  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                if (i_sts.pend_valid) n_state = S_PUSH;
                else if (i_sts.qual)  n_state = S_RD;
                else                  n_state = S_POST;
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = i_sts.qual ? S_RD : S_POST;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                if (i_sts.rd_done) n_state = i_sts.need_avg ? S_AVG : S_FIN;
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_MUL;
            end
            S_POST: begin
                n_state = i_sts.wrap ? S_ADVI : S_IDLE;
            end
            S_ADVI: begin
                o_cmd.adv_init = 1'b1;
                n_state        = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv_step = 1'b1;
                if (!i_sts.adv_more) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a result is pushed only once the pending slot has been decided
    a_push_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> (r_state == S_PUSH) && i_sts.pend_valid)
        else $error("push without pending result");
    // every finished window goes back to evaluate the next one
    a_fin_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_MUL))
        else $error("fin not followed by mul");
    // no new word while a pending result is still held
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> !i_sts.pend_valid)
        else $error("accept with pending result");
endmodule

// File: rtl/core/pma_dp.sv
// pma_dp: pooling datapath - position counters, window store, tap
// accumulation, reciprocal multiply and output register.
// Depends on pma_pkg and pma_ram.
module pma_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pma_pkg::t_cfg                          i_cfg,
    input  pma_pkg::t_cmd                          i_cmd,
    output pma_pkg::t_sts                          o_sts,
    input  logic signed [pma_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                   i_start_req,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pma_pkg::SAMPLE_BITS-1:0] o_pooled_value,
    output logic [9:0]                             o_out_column,
    output logic [5:0]                             o_out_channel,
    output logic                                   o_run_last
);
    localparam int SB  = pma_pkg::SAMPLE_BITS;
    localparam int KB  = pma_pkg::KER_BITS;
    localparam int SUB = pma_pkg::SUM_BITS;
    localparam int PB  = SUB + SB;

    // clamped configuration
    logic [3:0]  w_k, w_s;
    logic [6:0]  w_ch;
    logic [10:0] w_wu;

    always_comb begin
        w_k = i_cfg.kernel_size;
        if (w_k == 4'd0) w_k = 4'd1;
        if (w_k > 4'(pma_pkg::MAX_KERNEL)) w_k = 4'(pma_pkg::MAX_KERNEL);
        w_s = (i_cfg.stride == 4'd0) ? 4'd1 : i_cfg.stride;
        w_ch = i_cfg.channels;
        if (w_ch == 7'd0) w_ch = 7'd1;
        if (w_ch > 7'(pma_pkg::MAX_CHANNELS)) w_ch = 7'(pma_pkg::MAX_CHANNELS);
        w_wu = i_cfg.input_width;
        if (w_wu == 11'd0) w_wu = 11'd1;
        if (w_wu > 11'(pma_pkg::MAX_WIDTH)) w_wu = 11'(pma_pkg::MAX_WIDTH);
    end

    // position state
    logic [9:0]  r_in_col, r_x;
    logic [5:0]  r_in_ch, r_c;
    logic [10:0] r_nxt, r_o;
    logic [3:0]  r_n, r_j;
    logic        r_wrap, r_qual;
    logic [14:0] r_prod;
    logic signed [16:0] r_adv_raw;

    // normalized position of the incoming word
    logic [5:0]  w_ch_cur, w_ch_n;
    logic [9:0]  w_col_cur, w_col_n;
    logic [10:0] w_nxt_cur;
    logic        w_wrap;

    always_comb begin
        w_ch_cur  = i_start_req ? '0 : r_in_ch;
        w_col_cur = i_start_req ? '0 : r_in_col;
        w_nxt_cur = i_start_req ? '0 : r_nxt;
        w_ch_n    = ({1'b0, w_ch_cur} >= w_ch) ? '0 : w_ch_cur;
        w_col_n   = ({1'b0, w_col_cur} >= w_wu) ? 10'(w_wu - 11'd1) : w_col_cur;
        w_wrap    = ({1'b0, w_ch_n} + 7'd1) >= w_ch;
    end

    // window bounds
    logic signed [16:0] w_base, w_raw_e, w_p, w_x;
    logic               w_x_last, w_qual_now, w_inrange;

    assign w_base  = $signed({2'b00, r_prod}) - $signed({14'd0, i_cfg.pad_left});
    assign w_raw_e = w_base + $signed({13'd0, w_k}) - 17'sd1;
    assign w_p     = w_base + $signed({13'd0, r_j});
    assign w_x     = $signed({7'd0, r_x});
    assign w_x_last = ({1'b0, r_x} == (w_wu - 11'd1));
    // clamp(end) <= x  <=>  raw end <= x, or x is the last column
    assign w_qual_now = (r_o < i_cfg.output_width)
                     && (r_n < 4'(pma_pkg::MAX_RESULTS))
                     && ((w_raw_e <= w_x) || w_x_last);
    assign w_inrange = !w_p[16] && (w_p < $signed({6'd0, w_wu}));

    // window store
    logic [SB-1:0] w_rdata;

    pma_ram #(.WIDTH(SB), .DEPTH(pma_pkg::STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr ({w_col_n[KB-1:0], w_ch_n}),
        .i_wdata (i_sample),
        .i_raddr ({w_p[KB-1:0], r_c}),
        .o_rdata (w_rdata)
    );

    // tap accumulation
    logic                  r_tap_act, r_tap_vld, r_tap_first;
    logic signed [SB-1:0]  r_best, w_v;
    logic signed [SUB-1:0] r_sum;

    assign w_v = r_tap_vld ? $signed(w_rdata) : '0;

    // reciprocal multiply
    logic [SUB-1:0] w_mag, w_q, w_negq;
    logic [PB-1:0]  r_avg_prod;
    logic           r_avg_neg;
    logic [SB-1:0]  w_sat, w_val;

    assign w_mag  = r_sum[SUB-1] ? SUB'(-r_sum) : SUB'(r_sum);
    assign w_q    = r_avg_prod[PB-1:16];
    assign w_negq = SUB'(0) - w_q;

    always_comb begin
        if (r_avg_neg) begin
            w_sat = (w_q > SUB'(2 ** (SB - 1))) ? {1'b1, {(SB-1){1'b0}}} : w_negq[SB-1:0];
        end else begin
            w_sat = (w_q > SUB'(2 ** (SB - 1) - 1)) ? {1'b0, {(SB-1){1'b1}}} : w_q[SB-1:0];
        end
        if (!i_cfg.method)       w_val = r_best;
        else if (w_k == 4'd1)    w_val = r_sum[SB-1:0];
        else                     w_val = w_sat;
    end

    // pending result and output register
    logic          r_pend_valid, r_out_valid;
    logic [SB-1:0] r_pend, r_out_value;
    logic [9:0]    r_pend_col, r_out_col;
    logic [5:0]    r_out_ch;
    logic          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_ch      <= '0;
            r_nxt        <= '0;
            r_n          <= '0;
            r_j          <= '0;
            r_wrap       <= 1'b0;
            r_qual       <= 1'b0;
            r_tap_act    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_n      <= '0;
                r_nxt    <= w_nxt_cur;
                r_wrap   <= w_wrap;
                r_in_ch  <= w_wrap ? '0 : w_ch_n + 6'd1;
                r_in_col <= (w_wrap && ({1'b0, w_col_n} + 11'd1 < w_wu))
                            ? w_col_n + 10'd1 : w_col_n;
            end
            if (i_cmd.mul) begin
                r_j       <= '0;
                r_tap_act <= 1'b0;
            end
            if (i_cmd.cmp) r_qual <= w_qual_now;
            if (i_cmd.rd) begin
                r_tap_act <= (r_j < w_k);
                if (r_j < w_k) r_j <= r_j + 4'd1;
            end
            if (i_cmd.fin) begin
                r_pend_valid <= 1'b1;
                r_n          <= r_n + 4'd1;
            end
            if (i_cmd.push)            r_pend_valid <= 1'b0;
            if (i_cmd.push)            r_out_valid  <= 1'b1;
            else if (i_out_ready)      r_out_valid  <= 1'b0;
            if (i_cmd.adv_step && o_sts.adv_more) r_nxt <= r_nxt + 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c <= w_ch_n;
            r_x <= w_col_n;
            r_o <= w_nxt_cur;
        end
        if (i_cmd.mul) r_prod <= r_o * w_s;
        if (i_cmd.rd) begin
            r_tap_vld   <= w_inrange;
            r_tap_first <= (r_j == 4'd0);
            if (r_tap_act) begin
                if (r_tap_first) begin
                    r_best <= w_v;
                    r_sum  <= SUB'(w_v);
                end else begin
                    if (w_v > r_best) r_best <= w_v;
                    r_sum <= r_sum + SUB'(w_v);
                end
            end
        end
        if (i_cmd.avg) begin
            r_avg_prod <= {{SB{1'b0}}, w_mag} * {{SUB{1'b0}}, i_cfg.recip_kernel};
            r_avg_neg  <= r_sum[SUB-1];
        end
        if (i_cmd.fin) begin
            r_pend     <= w_val;
            r_pend_col <= r_o[9:0];
            r_o        <= r_o + 11'd1;
        end
        if (i_cmd.push) begin
            r_out_value <= r_pend;
            r_out_col   <= r_pend_col;
            r_out_ch    <= r_c;
            r_out_last  <= !r_qual;
        end
        if (i_cmd.adv_init) begin
            r_adv_raw <= $signed({2'b00, 15'({4'd0, r_nxt} * w_s)})
                       + $signed({13'd0, w_k}) - 17'sd1
                       - $signed({14'd0, i_cfg.pad_left});
        end else if (i_cmd.adv_step && o_sts.adv_more) begin
            r_adv_raw <= r_adv_raw + $signed({13'd0, w_s});
        end
    end

    always_comb begin
        o_sts.qual       = r_qual;
        o_sts.rd_done    = (r_j == w_k);
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.wrap       = r_wrap;
        o_sts.adv_more   = (r_nxt < i_cfg.output_width)
                        && ((r_adv_raw <= w_x) || w_x_last);
        o_sts.need_avg   = i_cfg.method && (w_k != 4'd1);
    end

    assign o_out_valid    = r_out_valid;
    assign o_pooled_value = r_out_value;
    assign o_out_column   = r_out_col;
    assign o_out_channel  = r_out_ch;
    assign o_run_last     = r_out_last;

    // output register is never overwritten while a word waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_out_value))
        else $error("output word overwritten");
    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> (r_n < 4'(pma_pkg::MAX_RESULTS)) && !r_pend_valid)
        else $error("result count or pending slot broken");
    a_tap_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_j <= w_k))
        else $error("tap index past kernel");
endmodule

// File: rtl/core/pool_1d_max_average_unit.sv
// Sequence: accept a word, multiply the window start, qualify; each emitted
// window waits on a held output, walks its taps, adds the average multiply
// for average pooling; a column-closing word then advances output columns.
// Throughput: one word at a time; the window tap walk (one store read per
// cycle) sets the pace. Reset: synchronous active-low i_rst_n clears counters,
// sequencer, output valid and loads register defaults; store is not cleared.
module pool_1d_max_average_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pma_in_if.sink                           i_in,
    pma_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pma_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    // configuration registers
    pma_pkg::t_cfg    r_cfg;
    pma_pkg::t_reg_idx w_idx;

    assign w_idx  = pma_pkg::t_reg_idx'(paddr[pma_pkg::PADDR_BITS-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.method       <= 1'b0;
            r_cfg.kernel_size  <= 4'd2;
            r_cfg.stride       <= 4'd2;
            r_cfg.channels     <= 7'd1;
            r_cfg.input_width  <= 11'd1;
            r_cfg.output_width <= 11'd1;
            r_cfg.pad_left     <= 3'd0;
            r_cfg.recip_kernel <= 16'h8000;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                pma_pkg::REG_METHOD:       r_cfg.method       <= pwdata[0];
                pma_pkg::REG_KERNEL_SIZE:  r_cfg.kernel_size  <= pwdata[3:0];
                pma_pkg::REG_STRIDE:       r_cfg.stride       <= pwdata[3:0];
                pma_pkg::REG_CHANNELS:     r_cfg.channels     <= pwdata[6:0];
                pma_pkg::REG_INPUT_WIDTH:  r_cfg.input_width  <= pwdata[10:0];
                pma_pkg::REG_OUTPUT_WIDTH: r_cfg.output_width <= pwdata[10:0];
                pma_pkg::REG_PAD_LEFT:     r_cfg.pad_left     <= pwdata[2:0];
                pma_pkg::REG_RECIP_KERNEL: r_cfg.recip_kernel <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            pma_pkg::REG_METHOD:       prdata = {31'd0, r_cfg.method};
            pma_pkg::REG_KERNEL_SIZE:  prdata = {28'd0, r_cfg.kernel_size};
            pma_pkg::REG_STRIDE:       prdata = {28'd0, r_cfg.stride};
            pma_pkg::REG_CHANNELS:     prdata = {25'd0, r_cfg.channels};
            pma_pkg::REG_INPUT_WIDTH:  prdata = {21'd0, r_cfg.input_width};
            pma_pkg::REG_OUTPUT_WIDTH: prdata = {21'd0, r_cfg.output_width};
            pma_pkg::REG_PAD_LEFT:     prdata = {29'd0, r_cfg.pad_left};
            pma_pkg::REG_RECIP_KERNEL: prdata = {16'd0, r_cfg.recip_kernel};
            default:                   prdata = '0;
        endcase
    end

    // sequencer <-> datapath
    pma_pkg::t_cmd w_cmd;
    pma_pkg::t_sts w_sts;

    pma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pma_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample       (i_in.sample),
        .i_start_req    (i_in.start_req),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_pooled_value (o_out.pooled_value),
        .o_out_column   (o_out.out_column),
        .o_out_channel  (o_out.out_channel),
        .o_run_last     (o_out.run_last)
    );
endmodule

// File: bench/pool_1d_max_average_unit_tb.sv
// Self-checking bench for pool_1d_max_average_unit: APB setup, sample stream and
// pooled word checks against an in-bench predictor.
// Depends on pma_pkg, pma_if and the unit RTL.
`timescale 1ns / 100ps

module pool_1d_max_average_unit_tb;

    localparam int CLK_HALF = 10;
    localparam int SETTLE_CYCLES = 160; // longest word: 8 windows of 8 taps plus column advance

    typedef struct {
        logic [15:0] value;
        logic [9:0]  column;
        logic [5:0]  channel;
        logic        last;
    } t_pooled_word;

    typedef struct {
        int method, kernel, step, chans, in_w, out_w, pad, recip;
    } t_pool_setup;

    // directed rows under reset settings (kernel 2, stride 2, one column)
    typedef struct {
        bit          start;
        logic [15:0] sample;
        bit          typed;
        logic [15:0] value;
    } t_lead_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [pma_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pma_in_if  in_if ();
    pma_out_if out_if ();

    pool_1d_max_average_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor state: register copy, window store, position counters
    // ---------------------------------------------------------------
    int pm_method, pm_kernel, pm_step, pm_chans, pm_in_w, pm_out_w, pm_pad, pm_recip;
    int win_store [pma_pkg::STORE_DEPTH];
    int cur_col, cur_chan, next_ocol;

    t_pooled_word pooled_expected[$];
    int  fail_count = 0;
    bit  no_idle = 1'b0;   // set for stretches with no gaps on either side
    bit  typed_pending = 1'b0;
    logic [15:0] typed_value;

    // last real input column touched by window o (clamped into the tensor)
    function automatic int window_end(int o, int k, int s, int w);
        int e;
        e = o * s + k - 1 - pm_pad;
        if (e < 0) e = 0;
        if (e > w - 1) e = w - 1;
        return e;
    endfunction

    function automatic logic [15:0] window_value(int o, int c, int k, int s, int w);
        int  first, p, v, best, sum;
        longint mag, r;
        first = o * s - pm_pad;
        best = 0;
        sum = 0;
        for (int j = 0; j < k; j++) begin
            p = first + j;
            v = 0;   // padding columns count as zero
            if (p >= 0 && p < w)
                v = win_store[(p % pma_pkg::MAX_KERNEL) * pma_pkg::MAX_CHANNELS + c];
            if (j == 0 || v > best) best = v;
            sum += v;
        end
        if (pm_method == 0) return best[15:0];
        if (k == 1) return sum[15:0];   // single tap: no multiply
        mag = (sum < 0) ? -longint'(sum) : longint'(sum);
        r = (mag * longint'(pm_recip)) >>> 16;
        if (sum < 0) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // one accepted word -> pooled words it causes
    task automatic predict_pool(logic [15:0] smp, bit start);
        int k, s, ch, w, o, n;
        t_pooled_word pw;
        k  = (pm_kernel < 1) ? 1 :
             (pm_kernel > pma_pkg::MAX_KERNEL ? pma_pkg::MAX_KERNEL : pm_kernel);
        s  = (pm_step < 1) ? 1 : pm_step;
        ch = (pm_chans < 1) ? 1 :
             (pm_chans > pma_pkg::MAX_CHANNELS ? pma_pkg::MAX_CHANNELS : pm_chans);
        w  = (pm_in_w < 1) ? 1 :
             (pm_in_w > pma_pkg::MAX_WIDTH ? pma_pkg::MAX_WIDTH : pm_in_w);
        n = 0;
        if (start) begin
            cur_col = 0;
            cur_chan = 0;
            next_ocol = 0;
        end
        if (cur_chan >= ch) cur_chan = 0;
        if (cur_col >= w) cur_col = w - 1;
        win_store[(cur_col % pma_pkg::MAX_KERNEL) * pma_pkg::MAX_CHANNELS + cur_chan] =
            int'($signed(smp));
        o = next_ocol;
        // at most MAX_RESULTS windows per word; the rest are dropped
        while (o < pm_out_w && n < pma_pkg::MAX_RESULTS
               && window_end(o, k, s, w) <= cur_col) begin
            pw.value   = window_value(o, cur_chan, k, s, w);
            pw.column  = o[9:0];
            pw.channel = cur_chan[5:0];
            pw.last    = 1'b0;
            if (n == 0 && typed_pending) pw.value = typed_value;
            pooled_expected.push_back(pw);
            n++;
            o++;
        end
        if (n > 0) pooled_expected[$].last = 1'b1;
        typed_pending = 1'b0;
        cur_chan++;
        if (cur_chan >= ch) begin
            cur_chan = 0;
            while (next_ocol < pm_out_w && window_end(next_ocol, k, s, w) <= cur_col)
                next_ocol++;
            if (cur_col + 1 < w) cur_col++;
        end
    endtask

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        if (no_idle) return 0;
        if ($urandom_range(0, 9) < 8)
            return ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ---------------------------------------------------------------
    // Output side: random stalls, checks on each accepted word
    // ---------------------------------------------------------------
    int stall_left = 0;
    initial out_if.ready = 1'b0;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            stall_left <= idle_len();
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pooled_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pooled_expected.size() == 0) begin
                $error("pooled word with none expected: value %h column %0d channel %0d",
                       out_if.pooled_value, out_if.out_column, out_if.out_channel);
                fail_count++;
            end else begin
                want = pooled_expected.pop_front();
                if (out_if.pooled_value !== want.value) begin
                    $error("pooled_value: expected %h, got %h", want.value, out_if.pooled_value);
                    fail_count++;
                end
                if (out_if.out_column !== want.column) begin
                    $error("out_column: expected %0d, got %0d", want.column, out_if.out_column);
                    fail_count++;
                end
                if (out_if.out_channel !== want.channel) begin
                    $error("out_channel: expected %0d, got %0d", want.channel,
                           out_if.out_channel);
                    fail_count++;
                end
                if (out_if.run_last !== want.last) begin
                    $error("run_last: expected %0b, got %0b", want.last, out_if.run_last);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    initial begin
        in_if.valid = 1'b0;
        in_if.sample = '0;
        in_if.start_req = 1'b0;
    end

    // called from a rising edge (or right after reset); returns at the accepting edge
    task automatic send_word(logic [15:0] smp, bit start);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.sample <= smp;
        in_if.start_req <= start;
        do @(posedge i_clk); while (!in_if.ready);
        predict_pool(smp, start);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pooled_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(pma_pkg::t_reg_idx idx, int val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pma_pkg::REG_METHOD:       pm_method = val & 1;
            pma_pkg::REG_KERNEL_SIZE:  pm_kernel = val & 'hF;
            pma_pkg::REG_STRIDE:       pm_step   = val & 'hF;
            pma_pkg::REG_CHANNELS:     pm_chans  = val & 'h7F;
            pma_pkg::REG_INPUT_WIDTH:  pm_in_w   = val & 'h7FF;
            pma_pkg::REG_OUTPUT_WIDTH: pm_out_w  = val & 'h7FF;
            pma_pkg::REG_PAD_LEFT:     pm_pad    = val & 'h7;
            pma_pkg::REG_RECIP_KERNEL: pm_recip  = val & 'hFFFF;
            default: ;
        endcase
    endtask

    task automatic load_setup(t_pool_setup cf);
        drain();
        apb_write(pma_pkg::REG_METHOD, cf.method);
        apb_write(pma_pkg::REG_KERNEL_SIZE, cf.kernel);
        apb_write(pma_pkg::REG_STRIDE, cf.step);
        apb_write(pma_pkg::REG_CHANNELS, cf.chans);
        apb_write(pma_pkg::REG_INPUT_WIDTH, cf.in_w);
        apb_write(pma_pkg::REG_OUTPUT_WIDTH, cf.out_w);
        apb_write(pma_pkg::REG_PAD_LEFT, cf.pad);
        apb_write(pma_pkg::REG_RECIP_KERNEL, cf.recip);
        @(posedge i_clk);
    endtask

    // one tensor under current settings; start on the first word, optionally
    // cut short (broken) or followed by words past the end (noise)
    task automatic send_tensor(int max_len, ref int sent);
        int ch, w, len;
        ch = (pm_chans < 1) ? 1 :
             (pm_chans > pma_pkg::MAX_CHANNELS ? pma_pkg::MAX_CHANNELS : pm_chans);
        w  = (pm_in_w < 1) ? 1 :
             (pm_in_w > pma_pkg::MAX_WIDTH ? pma_pkg::MAX_WIDTH : pm_in_w);
        len = ch * w;
        if (len > max_len) len = max_len;
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
        for (int i = 0; i < len; i++) begin
            send_word(16'($urandom_range(0, 65535)), i == 0);
            sent++;
        end
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_word(16'($urandom_range(0, 65535)), 1'b0);
    endtask

    function automatic t_pool_setup random_setup();
        t_pool_setup cf;
        int tot;
        cf.method = $urandom_range(0, 1);
        cf.kernel = $urandom_range(1, 8);
        cf.step   = $urandom_range(1, 8);
        cf.chans  = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        cf.in_w   = $urandom_range(1, 14);
        cf.recip  = 65536 / cf.kernel;
        if (cf.recip > 65535) cf.recip = 65535;
        if ($urandom_range(0, 7) == 0) cf.recip = $urandom_range(0, 65535);
        if ($urandom_range(0, 1) == 0 || cf.in_w < cf.kernel) begin
            // same padding
            cf.out_w = (cf.in_w + cf.step - 1) / cf.step;
            tot = (cf.out_w - 1) * cf.step + cf.kernel - cf.in_w;
            cf.pad = (tot > 0) ? tot / 2 : 0;
            if (cf.pad > 7) cf.pad = 7;
        end else begin
            // valid padding
            cf.out_w = (cf.in_w - cf.kernel) / cf.step + 1;
            cf.pad = 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            cf.pad = $urandom_range(0, 7);
            cf.out_w = $urandom_range(1, 16);
        end
        return cf;
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    t_lead_row lead_rows [5] = '{
        '{1'b1, 16'h7FFF, 1'b1, 16'h7FFF},  // largest sample beats the zero pad
        '{1'b0, 16'h8000, 1'b0, 16'h0000},  // past the end: held, nothing out
        '{1'b1, 16'h8000, 1'b1, 16'h0000},  // most negative loses to the zero pad
        '{1'b1, 16'h0001, 1'b1, 16'h0001},
        '{1'b0, 16'hFFFF, 1'b0, 16'h0000}
    };

    // directed settings: extremes, out-of-range values, both methods
    t_pool_setup edge_setups [12] = '{
        '{1, 1, 1, 1, 6, 6, 0, 0},             // average, kernel 1 passes through
        '{1, 8, 1, 2, 10, 10, 3, 8192},        // average, largest kernel
        '{0, 1, 1, 1, 4, 12, 7, 65535},        // windows inside left pad: eight per word
        '{1, 3, 8, 3, 9, 2, 1, 65535},         // average, stride 8, recip all ones
        '{0, 0, 0, 0, 0, 2, 0, 32768},         // zero kernel, stride, channels, width
        '{1, 15, 15, 2, 5, 3, 7, 0},           // kernel over the top, recip zero
        '{0, 2, 2, 127, 1, 1, 0, 32768},       // channels over the top: 64 channels
        '{1, 4, 1, 1, 2047, 5, 2, 16384},      // width over the top, partial tensor
        '{0, 3, 1, 2, 4, 0, 1, 21845},         // no output columns
        '{0, 2, 1, 1, 3, 2047, 0, 32768},      // output width over the top
        '{1, 2, 1, 1, 8, 9, 1, 32768},         // average at sum extremes
        '{0, 5, 2, 3, 7, 4, 2, 13107}
    };

    initial begin
        int sent;
        int max_len;
        sent = 0;
        pm_method = 0; pm_kernel = 2; pm_step = 2; pm_chans = 1;
        pm_in_w = 1; pm_out_w = 1; pm_pad = 0; pm_recip = 32768;
        cur_col = 0; cur_chan = 0; next_ocol = 0;
        foreach (win_store[i]) win_store[i] = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (lead_rows[i]) begin
            typed_pending = lead_rows[i].typed;
            typed_value = lead_rows[i].value;
            send_word(lead_rows[i].sample, lead_rows[i].start);
        end

        foreach (edge_setups[i]) begin
            load_setup(edge_setups[i]);
            max_len = (edge_setups[i].in_w > 64) ? 12 : 16;
            if (i == 10) begin
                // saturating sums: all max, then all min
                for (int j = 0; j < 8; j++) send_word(16'h7FFF, j == 0);
                for (int j = 0; j < 8; j++) send_word(16'h8000, j == 0);
            end else begin
                send_tensor(max_len, sent);
            end
        end

        sent = 0;
        while (sent < 32) begin
            load_setup(random_setup());
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) begin
                send_tensor(16, sent);
                // sender holds off until everything is out
                if ($urandom_range(0, 3) == 0) begin
                    @(negedge i_clk);
                    in_if.valid <= 1'b0;
                    while (pooled_expected.size() != 0) @(posedge i_clk);
                end
            end
        end
        no_idle = 1'b0;

        drain();
        if (fail_count == 0 && pooled_expected.size() == 0) begin
            $display("pool_1d_max_average_unit verification clean");
        end else begin
            $display("pool_1d_max_average_unit verification failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("pool_1d_max_average_unit verification failed");
        $finish;
    end

endmodule
